// ===== design/lcd_pkg.sv =====
package lcd_pkg;

  // Field widths fixed by the command and result formats.
  localparam int unsigned CmdW   = 16;
  localparam int unsigned AddrW  = 7;
  localparam int unsigned CapW   = 5;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned NotchW = 3;

  // Number of capacitor switches on the node.
  localparam int unsigned NumChannels = 3;

  // Special command words.
  localparam logic [CmdW-1:0] UnlockWord = 16'hD00D;
  localparam logic [CmdW-1:0] RelockWord = 16'hFFFF;

  // Capacitor subcommand code that copies current settings into the defaults.
  localparam logic [1:0] SubCopyDefaults = 2'b11;

  // Node address after reset.
  localparam logic [AddrW-1:0] NodeAddrReset = 7'd1;

  typedef logic [NumChannels-1:0][CapW-1:0] cap_vec_t;

  // One decoded command: either a single result or the relock load burst.
  typedef struct packed {
    logic                relock;
    logic                cap_load;
    logic [ChanW-1:0]    cap_channel;
    logic [CapW-1:0]     cap_value;
    cap_vec_t            reload;
    logic [NotchW-1:0]   notch_on;
    logic                is_unlocked;
  } grp_t;

endpackage

// ===== design/lcd_cmd_if.sv =====
interface lcd_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [lcd_pkg::CmdW-1:0]    command_word;

  modport source (output valid, output command_word, input ready);
  modport sink (input valid, input command_word, output ready);
endinterface

// ===== design/lcd_res_if.sv =====
interface lcd_res_if;
  logic                          valid;
  logic                          ready;
  logic                          cap_load;
  logic [lcd_pkg::ChanW-1:0]     cap_channel;
  logic [lcd_pkg::CapW-1:0]      cap_value;
  logic [lcd_pkg::NotchW-1:0]    notch_on;
  logic                          is_unlocked;
  logic                          last;

  modport source (output valid, output cap_load, output cap_channel, output cap_value,
                  output notch_on, output is_unlocked, output last, input ready);
  modport sink (input valid, input cap_load, input cap_channel, input cap_value,
                input notch_on, input is_unlocked, input last, output ready);
endinterface

// ===== design/lcd_decode.sv =====
module lcd_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lcd_pkg::AddrW-1:0]  cfg_wdata_i,
  lcd_cmd_if.sink                    cmd_i,
  output logic                       grp_valid_o,
  output lcd_pkg::grp_t              grp_o,
  input  logic                       grp_take_i
);
  import lcd_pkg::*;

  logic                in_valid_q;
  logic [CmdW-1:0]     word_q;
  logic [AddrW-1:0]    node_q;
  logic                unlocked_q, unlocked_d;
  logic [NotchW-1:0]   notch_q, notch_d;
  cap_vec_t            cap_q, cap_d;
  cap_vec_t            dflt_q, dflt_d;
  logic [7:0]          lo;
  logic [ChanW-1:0]    ch;
  logic                addressed;
  grp_t                grp;

  // Input register: refilled whenever it is empty or its word moves on.
  assign cmd_i.ready = !in_valid_q || grp_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      word_q <= cmd_i.command_word;
    end
  end

  // Node address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= NodeAddrReset;
    end else if (cfg_we_i) begin
      node_q <= cfg_wdata_i;
    end
  end

  assign lo        = word_q[7:0];
  assign ch        = lo[6:5];
  assign addressed = !word_q[CmdW-1] && ((word_q[14:8] & node_q) != '0);

  // Decode the held word against the current state.
  always_comb begin
    unlocked_d      = unlocked_q;
    notch_d         = notch_q;
    cap_d           = cap_q;
    dflt_d          = dflt_q;
    grp.relock      = 1'b0;
    grp.cap_load    = 1'b0;
    grp.cap_channel = '0;
    grp.cap_value   = '0;
    grp.reload      = dflt_q;

    if (!unlocked_q) begin
      if (word_q == UnlockWord) begin
        unlocked_d = 1'b1;
      end
    end else if (word_q == RelockWord) begin
      unlocked_d = 1'b0;
      notch_d    = '0;
      cap_d      = dflt_q;
      grp.relock = 1'b1;
    end else if (addressed) begin
      if (lo[7]) begin
        notch_d = (notch_q & ~lo[5:3]) | (lo[2:0] & lo[5:3]);
      end else if (ch == SubCopyDefaults) begin
        dflt_d = cap_q;
      end else if (ch < ChanW'(NumChannels)) begin
        for (int i = 0; i < NumChannels; i++) begin
          if (ch == ChanW'(i)) begin
            cap_d[i] = lo[CapW-1:0];
          end
        end
        grp.cap_load    = 1'b1;
        grp.cap_channel = ch;
        grp.cap_value   = lo[CapW-1:0];
      end
    end

    grp.notch_on    = notch_d;
    grp.is_unlocked = unlocked_d;
  end

  // State commits when the decoded group enters the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlocked_q <= 1'b0;
      notch_q    <= '0;
      cap_q      <= '0;
      dflt_q     <= '0;
    end else if (grp_take_i) begin
      unlocked_q <= unlocked_d;
      notch_q    <= notch_d;
      cap_q      <= cap_d;
      dflt_q     <= dflt_d;
    end
  end

  assign grp_valid_o = in_valid_q;
  assign grp_o       = grp;

endmodule

// ===== design/lcd_out.sv =====
module lcd_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           grp_valid_i,
  input  lcd_pkg::grp_t  grp_i,
  output logic           grp_take_o,
  lcd_res_if.source      res_o
);
  import lcd_pkg::*;

  logic               out_valid_q;
  logic [ChanW-1:0]   beat_q;
  grp_t               grp_q;
  logic               last_beat;
  logic               free;

  // A relock group spans one beat per channel; every other group is one beat.
  assign last_beat  = !grp_q.relock || (beat_q == ChanW'(NumChannels - 1));
  assign free       = !out_valid_q || (res_o.ready && last_beat);
  assign grp_take_o = grp_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= '0;
    end else if (free) begin
      out_valid_q <= grp_valid_i;
      beat_q      <= '0;
    end else if (res_o.ready) begin
      beat_q <= beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_take_o) begin
      grp_q <= grp_i;
    end
  end

  // Result fields for the current beat.
  assign res_o.valid       = out_valid_q;
  assign res_o.cap_load    = grp_q.relock || grp_q.cap_load;
  assign res_o.cap_channel = grp_q.relock ? beat_q : grp_q.cap_channel;
  assign res_o.cap_value   = grp_q.relock ? grp_q.reload[beat_q] : grp_q.cap_value;
  assign res_o.notch_on    = grp_q.notch_on;
  assign res_o.is_unlocked = grp_q.is_unlocked;
  assign res_o.last        = last_beat;

`ifndef SYNTHESIS
  // The beat counter stays within the channel range.
  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (beat_q <= ChanW'(NumChannels - 1)))
    else $error("beat counter out of range");

  // Single-result groups never advance past their first beat.
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !grp_q.relock) |-> (beat_q == '0))
    else $error("single-result group advanced its beat");

  // A taken non-final relock beat is followed by the next channel.
  a_beat_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_o.ready && !last_beat) |=>
      (out_valid_q && beat_q == $past(beat_q) + 1'b1))
    else $error("relock burst skipped or lost a beat");
`endif

endmodule

// ===== design/locked_command_decoder.sv =====
// Command decoder for one node, locked after reset.
// cmd_i is a valid/ready channel carrying one 16-bit command word per
// transaction. res_o is a valid/ready channel of result transactions; each
// command yields one result, except a relock, which yields one capacitor load
// per channel in channel order, with last set on the final one.
// cfg_we_i/cfg_wdata_i write the 7-bit node address; write only while idle.
// A command accepted on cmd_i sits in the input register, where it is decoded,
// then moves into the result register and is presented from there once the
// result stage is free.
// Throughput: one command per cycle for single-result commands while the
// receiver takes each result. A relock holds the result register for one
// load beat per channel, stepped by the beat counter in the result stage.
// Reset clears the node address to 1, locks the decoder, turns all notches
// off and zeroes the capacitor and default settings. No clearing pass.
// When the receiver stalls, the result register holds its transaction, the
// input register fills with the next command, and cmd_i.ready then drops
// until the result stage frees up.
module locked_command_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lcd_pkg::AddrW-1:0]  cfg_wdata_i,
  lcd_cmd_if.sink                    cmd_i,
  lcd_res_if.source                  res_o
);
  import lcd_pkg::*;

  logic  grp_valid;
  logic  grp_take;
  grp_t  grp;

  lcd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .grp_valid_o (grp_valid),
    .grp_o       (grp),
    .grp_take_i  (grp_take)
  );

  lcd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_i       (grp),
    .grp_take_o  (grp_take),
    .res_o       (res_o)
  );

endmodule
